// ----- rtl/swm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sliding window median filter.
// No dependencies; swm_cell.sv and sliding_window_median_filter.sv refer to this package by scoped names.
package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_BITS  = 32;
  localparam int IDX_BITS     = $clog2(MAX_WINDOW);
  localparam int CNT_BITS     = $clog2(MAX_WINDOW + 1);
  localparam int OUT_BITS     = SAMPLE_BITS + 1;
  localparam int WS_BITS      = 7;
  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
  localparam logic [WS_BITS-1:0] WS_RESET = WS_BITS'(3);

  // Value handed between neighbouring cells, with its "greater than sample" flag
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] val;
    logic                   gt;
  } swm_link_t;

  // Controls broadcast to every cell of the sorted chain
  typedef struct packed {
    logic                          upd;
    logic                          full;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] old;
  } swm_bcast_t;

endpackage

// ----- rtl/swm_ram.sv -----
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/swm_cell.sv -----
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one window value, drops the leaving sample and
// inserts the new one using only its own compares and its two neighbours. Uses swm_pkg.
module swm_cell (
  input  logic                               clk,
  input  swm_pkg::swm_bcast_t                bc,
  input  logic                               below_n,   // cell holds a value now
  input  logic                               below_m,   // cell holds a value after removal
  input  swm_pkg::swm_link_t                 above_i,   // held value of the cell above
  input  swm_pkg::swm_link_t                 below_i,   // post-removal value of cell below
  output swm_pkg::swm_link_t                 up_o,
  output swm_pkg::swm_link_t                 dn_o,
  output logic [swm_pkg::SAMPLE_BITS-1:0]    val_o
);

  logic [swm_pkg::SAMPLE_BITS-1:0] val_r;
  logic [swm_pkg::SAMPLE_BITS-1:0] val_nxt;
  logic [swm_pkg::SAMPLE_BITS-1:0] rem_val;
  logic                            gt_own;
  logic                            ge_old;
  logic                            shift;
  logic                            rem_gt;

  // Compare own value with the new and the leaving sample; empty cells count as +inf
  assign gt_own = !below_n || ($signed(val_r) > bc.sample);
  assign ge_old = below_n && ($signed(val_r) >= bc.old);

  // Removal: cells at or above the first copy of the leaving value take from above
  assign shift   = bc.full && ge_old;
  assign rem_val = shift ? above_i.val : val_r;
  assign rem_gt  = !below_m || (shift ? above_i.gt : gt_own);

  // Insertion: above the new sample, take from below or take the sample itself
  always_comb begin
    if (rem_gt) begin
      val_nxt = below_i.gt ? below_i.val : bc.sample;
    end else begin
      val_nxt = rem_val;
    end
  end

  // Hold unless an update is broadcast
  always_ff @(posedge clk) begin
    if (bc.upd) begin
      val_r <= val_nxt;
    end
  end

  assign up_o  = '{val: val_r, gt: gt_own};
  assign dn_o  = '{val: rem_val, gt: rem_gt};
  assign val_o = val_r;

endmodule

// ----- rtl/sliding_window_median_filter.sv -----
`timescale 1ns / 1ps
// Top level of the sliding window median filter: history RAM, sorted cell chain,
// median pick and output register. Depends on swm_pkg, swm_ram and swm_cell.
//
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | in_tdata: sample
//  out_    | master    | out_tvalid/tready   | out_tdata: median_x2
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_data: window_size
//
// An emitting sample goes through these steps in order: accept and read the leaving sample from the
// history RAM, update the sorted chain, pick the middle entries, add them into the
// output. A sample that only fills the window skips the add step.
// The last step waits while an earlier result still sits unread in the output register.
// rst_n (synchronous) sets window_size to 3 and empties the window; a window_size
// write empties it too. Configuration is ready only while no sample is in flight.
module sliding_window_median_filter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [swm_pkg::IN_TDATA_BITS-1:0]     in_tdata,   // [31:0] sample
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [swm_pkg::OUT_TDATA_BITS-1:0]    out_tdata,  // [32:0] median_x2, rest zero
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swm_pkg::WS_BITS-1:0]           cfg_data    // [6:0] window_size
);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_PICK, ST_SUM} state_t;

  state_t                           state_r, state_nxt;
  logic [swm_pkg::SAMPLE_BITS-1:0]  sample_r, sample_nxt;
  logic [swm_pkg::WS_BITS-1:0]      ws_r, ws_nxt;
  logic [swm_pkg::CNT_BITS-1:0]     fill_r, fill_nxt;
  logic [swm_pkg::IDX_BITS-1:0]     oldest_r, oldest_nxt;
  logic                             emit_r, emit_nxt;
  logic [swm_pkg::SAMPLE_BITS-1:0]  lo_r, lo_nxt;
  logic [swm_pkg::SAMPLE_BITS-1:0]  hi_r, hi_nxt;
  logic                             out_tvalid_r, out_tvalid_nxt;
  logic [swm_pkg::OUT_BITS-1:0]     out_data_r, out_data_nxt;

  logic [swm_pkg::CNT_BITS-1:0]     win;
  logic                             full;
  logic [swm_pkg::CNT_BITS-1:0]     m_cnt;
  logic [swm_pkg::IDX_BITS-1:0]     mid;
  logic [swm_pkg::IDX_BITS-1:0]     lo_idx;
  logic [swm_pkg::SAMPLE_BITS-1:0]  old_val;
  logic                             ram_we;
  logic [swm_pkg::IDX_BITS-1:0]     ram_waddr;
  logic [swm_pkg::IDX_BITS-1:0]     oldest_inc;
  logic                             in_acc;
  logic                             cfg_acc;
  logic                             out_free;
  swm_pkg::swm_bcast_t              bc;

  swm_pkg::swm_link_t               up_l   [swm_pkg::MAX_WINDOW];
  swm_pkg::swm_link_t               dn_l   [swm_pkg::MAX_WINDOW];
  swm_pkg::swm_link_t               above_l[swm_pkg::MAX_WINDOW];
  swm_pkg::swm_link_t               below_l[swm_pkg::MAX_WINDOW];
  logic [swm_pkg::SAMPLE_BITS-1:0]  cell_val[swm_pkg::MAX_WINDOW];
  logic [swm_pkg::MAX_WINDOW-1:0]   bn;
  logic [swm_pkg::MAX_WINDOW-1:0]   bm;

  // Effective window: zero acts as one, anything past the maximum saturates
  always_comb begin
    if (ws_r == '0) begin
      win = swm_pkg::CNT_BITS'(1);
    end else if (ws_r > swm_pkg::WS_BITS'(swm_pkg::MAX_WINDOW)) begin
      win = swm_pkg::CNT_BITS'(swm_pkg::MAX_WINDOW);
    end else begin
      win = swm_pkg::CNT_BITS'(ws_r);
    end
  end

  assign full  = (fill_r == win);
  assign m_cnt = full ? fill_r - swm_pkg::CNT_BITS'(1) : fill_r;
  assign mid   = win[swm_pkg::CNT_BITS-1:1];
  assign lo_idx = win[0] ? mid : mid - swm_pkg::IDX_BITS'(1);
  assign oldest_inc = oldest_r + swm_pkg::IDX_BITS'(1);

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = (state_r == ST_IDLE);
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = swm_pkg::OUT_TDATA_BITS'(out_data_r);

  // History RAM: read the leaving sample at accept, overwrite it during the update (or fill the next free slot)
  assign ram_we    = (state_r == ST_UPD);
  assign ram_waddr = full ? oldest_r : fill_r[swm_pkg::IDX_BITS-1:0];

  swm_ram #(
    .WIDTH(swm_pkg::SAMPLE_BITS),
    .DEPTH(swm_pkg::MAX_WINDOW)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(sample_r),
    .raddr(oldest_r),
    .rdata(old_val)
  );

  // Broadcast to the chain
  assign bc = '{upd: ram_we, full: full, sample: $signed(sample_r), old: $signed(old_val)};

  // Sorted chain of cells, each linked to its two neighbours
  for (genvar i = 0; i < swm_pkg::MAX_WINDOW; i++) begin : g_cell
    assign bn[i] = (swm_pkg::CNT_BITS'(i) < fill_r);
    assign bm[i] = (swm_pkg::CNT_BITS'(i) < m_cnt);

    if (i == swm_pkg::MAX_WINDOW - 1) begin : g_top
      assign above_l[i] = '{val: '0, gt: 1'b1};
    end else begin : g_mid_up
      assign above_l[i] = up_l[i+1];
    end

    if (i == 0) begin : g_bot
      assign below_l[i] = '{val: '0, gt: 1'b0};
    end else begin : g_mid_dn
      assign below_l[i] = dn_l[i-1];
    end

    swm_cell u_cell (
      .clk    (clk),
      .bc     (bc),
      .below_n(bn[i]),
      .below_m(bm[i]),
      .above_i(above_l[i]),
      .below_i(below_l[i]),
      .up_o   (up_l[i]),
      .dn_o   (dn_l[i]),
      .val_o  (cell_val[i])
    );
  end

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    sample_nxt     = sample_r;
    ws_nxt         = ws_r;
    fill_nxt       = fill_r;
    oldest_nxt     = oldest_r;
    emit_nxt       = emit_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;

    // Drop a result once its transaction completes
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          ws_nxt     = cfg_data;
          fill_nxt   = '0;
          oldest_nxt = '0;
        end
        if (in_acc) begin
          sample_nxt = in_tdata[swm_pkg::SAMPLE_BITS-1:0];
          state_nxt  = ST_UPD;
        end
      end
      ST_UPD: begin
        // Advance fill count or the oldest slot
        if (full) begin
          oldest_nxt = (swm_pkg::CNT_BITS'(oldest_inc) >= win || oldest_inc == '0)
                       ? '0 : oldest_inc;
          emit_nxt   = 1'b1;
        end else begin
          fill_nxt   = fill_r + swm_pkg::CNT_BITS'(1);
          oldest_nxt = '0;
          emit_nxt   = (fill_r + swm_pkg::CNT_BITS'(1) == win);
        end
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        lo_nxt    = cell_val[lo_idx];
        hi_nxt    = cell_val[mid];
        state_nxt = emit_r ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        // Hold until the output register is free
        if (out_free) begin
          out_data_nxt   = {lo_r[swm_pkg::SAMPLE_BITS-1], lo_r}
                         + {hi_r[swm_pkg::SAMPLE_BITS-1], hi_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, control and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ws_r         <= swm_pkg::WS_RESET;
      fill_r       <= '0;
      oldest_r     <= '0;
      emit_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ws_r         <= ws_nxt;
      fill_r       <= fill_nxt;
      oldest_r     <= oldest_nxt;
      emit_r       <= emit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    sample_r   <= sample_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
